// ----- rtl/core/midi_track_event_parser_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTEP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("midi track event parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("midi track event parser check failed");

`endif

// ----- rtl/core/mtep_pkg.sv -----
package mtep_pkg;

    localparam int TRACK_COUNT = 16;
    localparam int TRACK_W     = 4;
    localparam int TRACK_SPAN  = 1 << TRACK_W;
    localparam int RUN_DEPTH   = (TRACK_COUNT < TRACK_SPAN) ? TRACK_COUNT : TRACK_SPAN;
    localparam int RUN_AW      = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

    localparam int DELTA_W   = 32;
    localparam int KIND_W    = 2;
    localparam int NOTE_W    = 8;
    localparam int CHAN_W    = 4;
    localparam int TEMPO_W   = 24;
    localparam int RESULT_W  = DELTA_W + KIND_W + NOTE_W + CHAN_W + TEMPO_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam int KIND_LSB  = DELTA_W;
    localparam int NOTE_LSB  = KIND_LSB + KIND_W;
    localparam int CHAN_LSB  = NOTE_LSB + NOTE_W;
    localparam int TEMPO_LSB = CHAN_LSB + CHAN_W;

    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_ESC   = 8'hF7;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_EOT    = 8'h2F;

    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_PRESSURE = 4'hD;

    localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TEMPO    = 2'd3;

    typedef enum logic [8:0] {
        ST_DELTA     = 9'b000000001,
        ST_STATUS    = 9'b000000010,
        ST_PARAM1    = 9'b000000100,
        ST_PARAM2    = 9'b000001000,
        ST_META_TYPE = 9'b000010000,
        ST_META_LEN  = 9'b000100000,
        ST_TEMPO     = 9'b001000000,
        ST_SYS_LEN   = 9'b010000000,
        ST_SKIP      = 9'b100000000
    } parse_state_t;

    typedef logic [RUN_AW-1:0] track_map_t [TRACK_SPAN];

    function automatic track_map_t build_track_map();
        track_map_t map;
        for (int i = 0; i < TRACK_SPAN; i++) begin
            map[i] = RUN_AW'(i % TRACK_COUNT);
        end
        return map;
    endfunction

    localparam track_map_t TRACK_MAP = build_track_map();

endpackage

// ----- rtl/core/midi_track_event_parser.sv -----
// Parses standard MIDI file track bytes, one byte per request, each tagged with its
// track on s_tuser so that running status is kept per track. A request on the output
// is sent when an event completes: delta time, kind, note, channel and tempo on m_tdata,
// with m_tlast set for the end-of-track meta event. One byte is taken every clock cycle
// when the output is not stalled; a result is registered from the byte that completes
// its event through the input register, the single stage of parse logic and the
// result register. The output register lets a new byte enter while a result waits.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic [TRACK_W-1:0]   s_tuser,   // track
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // delta_ticks, event_kind, note, channel, tempo
    output logic                 m_tlast    // end_of_track
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic [TRACK_W-1:0] in_track_reg;

    parse_state_t         stage_reg, stage_next;
    logic [DELTA_W-1:0]   vlq_reg, vlq_next;
    logic [DELTA_W-1:0]   held_delta_reg, held_delta_next;
    logic [DELTA_W-1:0]   skip_reg, skip_next;
    logic [7:0]           meta_kind_reg, meta_kind_next;
    logic [TEMPO_W-1:0]   tempo_acc_reg, tempo_acc_next;
    logic [1:0]           tempo_seen_reg, tempo_seen_next;
    logic [3:0]           cur_status_reg, cur_status_next;
    logic [3:0]           cur_chan_reg, cur_chan_next;
    logic [7:0]           first_param_reg, first_param_next;
    logic [3:0]           run_type_reg [RUN_DEPTH];
    logic [3:0]           run_chan_reg [RUN_DEPTH];

    logic                 m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0]  m_data_reg;
    logic                 m_last_reg;

    logic                 advance;
    logic [RUN_AW-1:0]    run_idx;
    logic                 run_wr;
    logic                 emit;
    logic [KIND_W-1:0]    res_kind;
    logic [NOTE_W-1:0]    res_note;
    logic [CHAN_W-1:0]    res_chan;
    logic [TEMPO_W-1:0]   res_tempo;
    logic                 res_eot;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign run_idx  = TRACK_MAP[in_track_reg];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, m_data_reg};
    assign m_tlast  = m_last_reg;

    always_comb begin
        logic [DELTA_W-1:0] vlq_sum;
        logic               vlq_done;
        logic [3:0]         ch_type;
        logic [7:0]         second;
        logic               ch_emit;
        logic               meta_emit;
        logic [DELTA_W-1:0] skip_dec;

        stage_next       = stage_reg;
        vlq_next         = vlq_reg;
        held_delta_next  = held_delta_reg;
        skip_next        = skip_reg;
        meta_kind_next   = meta_kind_reg;
        tempo_acc_next   = tempo_acc_reg;
        tempo_seen_next  = tempo_seen_reg;
        cur_status_next  = cur_status_reg;
        cur_chan_next    = cur_chan_reg;
        first_param_next = first_param_reg;
        run_wr           = 1'b0;
        ch_emit          = 1'b0;
        meta_emit        = 1'b0;
        second           = 8'd1;

        vlq_sum  = {vlq_reg[DELTA_W-8:0], 7'd0} | {{(DELTA_W - 7){1'b0}}, in_byte_reg[6:0]};
        vlq_done = !in_byte_reg[7];
        skip_dec = (skip_reg != '0) ? skip_reg - DELTA_W'(1) : '0;

        case (stage_reg)
            ST_DELTA: begin
                vlq_next = vlq_sum;
                if (vlq_done) begin
                    held_delta_next = vlq_sum;
                    vlq_next        = '0;
                    stage_next      = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (in_byte_reg == META_STATUS) begin
                    stage_next = ST_META_TYPE;
                end else if (in_byte_reg == SYSEX_START || in_byte_reg == SYSEX_ESC) begin
                    vlq_next   = '0;
                    stage_next = ST_SYS_LEN;
                end else if (in_byte_reg[7]) begin
                    cur_status_next = in_byte_reg[7:4];
                    cur_chan_next   = in_byte_reg[3:0];
                    run_wr          = 1'b1;
                    stage_next      = ST_PARAM1;
                end else begin
                    cur_status_next  = run_type_reg[run_idx];
                    cur_chan_next    = run_chan_reg[run_idx];
                    first_param_next = in_byte_reg;
                    if (cur_status_next inside {TYPE_PROGRAM, TYPE_PRESSURE}) begin
                        ch_emit = 1'b1;
                    end else begin
                        stage_next = ST_PARAM2;
                    end
                end
            end
            ST_PARAM1: begin
                first_param_next = in_byte_reg;
                if (cur_status_reg inside {TYPE_PROGRAM, TYPE_PRESSURE}) begin
                    ch_emit = 1'b1;
                end else begin
                    stage_next = ST_PARAM2;
                end
            end
            ST_PARAM2: begin
                second  = in_byte_reg;
                ch_emit = 1'b1;
            end
            ST_META_TYPE: begin
                meta_kind_next = in_byte_reg;
                vlq_next       = '0;
                stage_next     = ST_META_LEN;
            end
            ST_META_LEN: begin
                vlq_next = vlq_sum;
                if (vlq_done) begin
                    vlq_next = '0;
                    if (meta_kind_reg == META_TEMPO) begin
                        skip_next       = (vlq_sum > DELTA_W'(3)) ? vlq_sum - DELTA_W'(3) : '0;
                        tempo_acc_next  = '0;
                        tempo_seen_next = '0;
                        stage_next      = ST_TEMPO;
                    end else begin
                        skip_next = vlq_sum;
                        if (vlq_sum == '0) begin
                            meta_emit = 1'b1;
                        end else begin
                            stage_next = ST_SKIP;
                        end
                    end
                end
            end
            ST_TEMPO: begin
                tempo_acc_next  = {tempo_acc_reg[TEMPO_W-9:0], in_byte_reg};
                tempo_seen_next = tempo_seen_reg + 2'd1;
                if (tempo_seen_next == 2'd3) begin
                    tempo_seen_next = '0;
                    if (skip_reg == '0) begin
                        meta_emit = 1'b1;
                    end else begin
                        stage_next = ST_SKIP;
                    end
                end
            end
            ST_SYS_LEN: begin
                vlq_next = vlq_sum;
                if (vlq_done) begin
                    skip_next      = vlq_sum;
                    vlq_next       = '0;
                    meta_kind_next = '0;
                    if (vlq_sum == '0) begin
                        meta_emit = 1'b1;
                    end else begin
                        stage_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    meta_emit = 1'b1;
                end
            end
            default: begin
                stage_next = ST_DELTA;
            end
        endcase

        res_kind  = KIND_IGNORED;
        res_note  = '0;
        res_chan  = '0;
        res_tempo = '0;
        res_eot   = 1'b0;

        if (ch_emit) begin
            ch_type = cur_status_next;
            if (ch_type == TYPE_NOTE_ON && second == 8'd0) begin
                ch_type = TYPE_NOTE_OFF;
            end
            if (ch_type == TYPE_NOTE_OFF || ch_type == TYPE_NOTE_ON) begin
                res_kind = (ch_type == TYPE_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
                res_note = first_param_next;
                res_chan = cur_chan_next;
            end
        end else begin
            ch_type = cur_status_next;
        end

        if (meta_emit) begin
            if (meta_kind_next == META_TEMPO) begin
                res_kind  = KIND_TEMPO;
                res_tempo = tempo_acc_next;
            end else begin
                res_eot = (meta_kind_next == META_EOT);
            end
        end

        emit = ch_emit || meta_emit;
        if (emit) begin
            stage_next = ST_DELTA;
        end

        if (advance) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_track_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg       <= ST_DELTA;
            vlq_reg         <= '0;
            held_delta_reg  <= '0;
            skip_reg        <= '0;
            meta_kind_reg   <= '0;
            tempo_acc_reg   <= '0;
            tempo_seen_reg  <= '0;
            cur_status_reg  <= '0;
            cur_chan_reg    <= '0;
            first_param_reg <= '0;
            for (int i = 0; i < RUN_DEPTH; i++) begin
                run_type_reg[i] <= '0;
                run_chan_reg[i] <= '0;
            end
        end else if (advance) begin
            stage_reg       <= stage_next;
            vlq_reg         <= vlq_next;
            held_delta_reg  <= held_delta_next;
            skip_reg        <= skip_next;
            meta_kind_reg   <= meta_kind_next;
            tempo_acc_reg   <= tempo_acc_next;
            tempo_seen_reg  <= tempo_seen_next;
            cur_status_reg  <= cur_status_next;
            cur_chan_reg    <= cur_chan_next;
            first_param_reg <= first_param_next;
            if (run_wr) begin
                run_type_reg[run_idx] <= cur_status_next;
                run_chan_reg[run_idx] <= cur_chan_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            m_data_reg <= {res_tempo, res_chan, res_note, res_kind, held_delta_next};
            m_last_reg <= res_eot;
        end
    end

endmodule

// ----- rtl/core/mtep_checker.sv -----
`include "midi_track_event_parser_macros.svh"

module mtep_checker
    import mtep_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic [KIND_W-1:0]  kind;
    logic [NOTE_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [TEMPO_W-1:0] tempo;
    logic               stalled;
    logic               plain_kind;

    assign kind  = m_tdata[KIND_LSB +: KIND_W];
    assign note  = m_tdata[NOTE_LSB +: NOTE_W];
    assign chan  = m_tdata[CHAN_LSB +: CHAN_W];
    assign tempo = m_tdata[TEMPO_LSB +: TEMPO_W];

    assign stalled    = m_tvalid && !m_tready;
    assign plain_kind = (kind == KIND_IGNORED) || (kind == KIND_TEMPO);

    // A stalled result request must hold its contents.
    `MTEP_ASSERT_NEXT(a_stall_holds, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // End of track is reported as an ignored event without tempo.
    `MTEP_ASSERT_SAME(a_eot_plain, m_tvalid && m_tlast, kind == KIND_IGNORED && tempo == '0)

    // Only a tempo event carries a tempo value.
    `MTEP_ASSERT_SAME(a_tempo_only, m_tvalid && kind != KIND_TEMPO, tempo == '0)

    // Note and channel are zero unless the event is a note event.
    `MTEP_ASSERT_SAME(a_note_only, m_tvalid && plain_kind, note == '0 && chan == '0)

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mtep_pkg::*;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [KIND_W-1:0]  kind;
        logic [NOTE_W-1:0]  note;
        logic [CHAN_W-1:0]  chan;
        logic [TEMPO_W-1:0] tempo;
        logic               eot;
    } event_rec_t;

    typedef struct {
        logic [TRACK_W-1:0] trk;
        logic [7:0]         byt;
        bit                 typed;
        event_rec_t         want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;   // data_byte
    logic [TRACK_W-1:0]   s_tuser = '0;   // track
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // delta_ticks, event_kind, note, channel, tempo
    logic                 m_tlast;        // end_of_track

    midi_track_event_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Directed bytes: running status before any status, the longest delta with a
    // zero-velocity note on, running note on, a long tempo event and end of track.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd0,  8'h00, 1'b0, '0},
        '{4'd0,  8'h3C, 1'b0, '0},
        '{4'd0,  8'h40, 1'b1, '{32'd0, KIND_IGNORED, 8'd0, 4'd0, 24'd0, 1'b0}},
        '{4'd15, 8'hFF, 1'b0, '0},
        '{4'd15, 8'hFF, 1'b0, '0},
        '{4'd15, 8'hFF, 1'b0, '0},
        '{4'd15, 8'h7F, 1'b0, '0},
        '{4'd15, {TYPE_NOTE_ON, 4'hF}, 1'b0, '0},
        '{4'd15, 8'h7F, 1'b0, '0},
        '{4'd15, 8'h00, 1'b1,
          '{32'h0FFF_FFFF, KIND_NOTE_OFF, 8'h7F, 4'hF, 24'd0, 1'b0}},
        '{4'd15, 8'h00, 1'b0, '0},
        '{4'd15, 8'h00, 1'b0, '0},
        '{4'd15, 8'h7F, 1'b1, '{32'd0, KIND_NOTE_ON, 8'h00, 4'hF, 24'd0, 1'b0}},
        '{4'd3,  8'h00, 1'b0, '0},
        '{4'd3,  META_STATUS, 1'b0, '0},
        '{4'd3,  META_TEMPO, 1'b0, '0},
        '{4'd3,  8'h04, 1'b0, '0},
        '{4'd3,  8'hFF, 1'b0, '0},
        '{4'd3,  8'hFF, 1'b0, '0},
        '{4'd3,  8'hFF, 1'b0, '0},
        '{4'd3,  8'hAA, 1'b1, '{32'd0, KIND_TEMPO, 8'd0, 4'd0, 24'hFF_FFFF, 1'b0}},
        '{4'd8,  8'h00, 1'b0, '0},
        '{4'd8,  META_STATUS, 1'b0, '0},
        '{4'd8,  META_EOT, 1'b0, '0},
        '{4'd8,  8'h00, 1'b1, '{32'd0, KIND_IGNORED, 8'd0, 4'd0, 24'd0, 1'b1}}
    };

    parse_state_t prs_stage = ST_DELTA;
    logic [31:0]  vlq_acc = '0;
    logic [31:0]  ev_delta = '0;
    logic [31:0]  skip_left = '0;
    logic [7:0]   meta_code = '0;
    logic [7:0]   param_a = '0;
    logic [23:0]  tempo_acc = '0;
    logic [1:0]   tempo_cnt = '0;
    logic [3:0]   cur_type = '0;
    logic [3:0]   cur_chan = '0;
    logic [3:0]   run_type [TRACK_COUNT] = '{default: '0};
    logic [3:0]   run_chan [TRACK_COUNT] = '{default: '0};

    event_rec_t   pending_events [$];
    int unsigned  mismatches = 0;
    int unsigned  bytes_sent = 0;
    bit           tx_quiet = 1'b0;

    function automatic event_rec_t make_event(input logic [KIND_W-1:0] kind,
                                              input logic [7:0] note, input logic [3:0] chan,
                                              input logic [23:0] tempo, input logic eot);
        event_rec_t r;
        r.delta = ev_delta;
        r.kind  = kind;
        r.note  = note;
        r.chan  = chan;
        r.tempo = tempo;
        r.eot   = eot;
        prs_stage = ST_DELTA;
        return r;
    endfunction

    function automatic event_rec_t payload_event();
        if (meta_code == META_TEMPO) begin
            return make_event(KIND_TEMPO, 8'd0, 4'd0, tempo_acc, 1'b0);
        end
        return make_event(KIND_IGNORED, 8'd0, 4'd0, 24'd0, meta_code == META_EOT);
    endfunction

    function automatic event_rec_t channel_event(input logic [7:0] second);
        logic [3:0] ty;
        ty = cur_type;
        if (ty == TYPE_NOTE_ON && second == 8'd0) begin
            ty = TYPE_NOTE_OFF;
        end
        if (ty == TYPE_NOTE_OFF) begin
            return make_event(KIND_NOTE_OFF, param_a, cur_chan, 24'd0, 1'b0);
        end
        if (ty == TYPE_NOTE_ON) begin
            return make_event(KIND_NOTE_ON, param_a, cur_chan, 24'd0, 1'b0);
        end
        return make_event(KIND_IGNORED, 8'd0, 4'd0, 24'd0, 1'b0);
    endfunction

    function automatic bit vlq_push(input logic [7:0] b);
        vlq_acc = (vlq_acc << 7) + {25'd0, b[6:0]};
        return !b[7];
    endfunction

    function automatic bit single_param();
        return cur_type == TYPE_PROGRAM || cur_type == TYPE_PRESSURE;
    endfunction

    // Advances the parse state by one byte; returns 1 when an event completes.
    function automatic bit midi_parse_byte(input logic [3:0] trk, input logic [7:0] b,
                                           output event_rec_t r);
        int unsigned t;
        logic [31:0] len;
        bit          got;
        t   = trk % TRACK_COUNT;
        r   = '0;
        got = 1'b0;
        case (prs_stage)
            ST_DELTA: begin
                if (vlq_push(b)) begin
                    ev_delta  = vlq_acc;
                    vlq_acc   = '0;
                    prs_stage = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (b == META_STATUS) begin
                    prs_stage = ST_META_TYPE;
                end else if (b == SYSEX_START || b == SYSEX_ESC) begin
                    vlq_acc   = '0;
                    prs_stage = ST_SYS_LEN;
                end else if (b[7]) begin
                    cur_type    = b[7:4];
                    cur_chan    = b[3:0];
                    run_type[t] = b[7:4];
                    run_chan[t] = b[3:0];
                    prs_stage   = ST_PARAM1;
                end else begin
                    cur_type = run_type[t];
                    cur_chan = run_chan[t];
                    param_a  = b;
                    if (single_param()) begin
                        r   = channel_event(8'd1);
                        got = 1'b1;
                    end else begin
                        prs_stage = ST_PARAM2;
                    end
                end
            end
            ST_PARAM1: begin
                param_a = b;
                if (single_param()) begin
                    r   = channel_event(8'd1);
                    got = 1'b1;
                end else begin
                    prs_stage = ST_PARAM2;
                end
            end
            ST_PARAM2: begin
                r   = channel_event(b);
                got = 1'b1;
            end
            ST_META_TYPE: begin
                meta_code = b;
                vlq_acc   = '0;
                prs_stage = ST_META_LEN;
            end
            ST_META_LEN: begin
                if (vlq_push(b)) begin
                    len     = vlq_acc;
                    vlq_acc = '0;
                    if (meta_code == META_TEMPO) begin
                        skip_left = (len > 32'd3) ? len - 32'd3 : 32'd0;
                        tempo_acc = '0;
                        tempo_cnt = '0;
                        prs_stage = ST_TEMPO;
                    end else begin
                        skip_left = len;
                        if (len == 32'd0) begin
                            r   = payload_event();
                            got = 1'b1;
                        end else begin
                            prs_stage = ST_SKIP;
                        end
                    end
                end
            end
            ST_TEMPO: begin
                tempo_acc = {tempo_acc[15:0], b};
                tempo_cnt = tempo_cnt + 2'd1;
                if (tempo_cnt == 2'd3) begin
                    tempo_cnt = '0;
                    if (skip_left == 32'd0) begin
                        r   = payload_event();
                        got = 1'b1;
                    end else begin
                        prs_stage = ST_SKIP;
                    end
                end
            end
            ST_SYS_LEN: begin
                if (vlq_push(b)) begin
                    skip_left = vlq_acc;
                    vlq_acc   = '0;
                    meta_code = '0;
                    if (skip_left == 32'd0) begin
                        r   = payload_event();
                        got = 1'b1;
                    end else begin
                        prs_stage = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                if (skip_left > 32'd0) begin
                    skip_left = skip_left - 32'd1;
                end
                if (skip_left == 32'd0) begin
                    r   = payload_event();
                    got = 1'b1;
                end
            end
            default: begin
                prs_stage = ST_DELTA;
            end
        endcase
        return got;
    endfunction

    task automatic deliver_byte(input logic [3:0] trk, input logic [7:0] byt,
                                input bit typed, input event_rec_t want);
        int unsigned gap;
        event_rec_t  ev;
        if ($urandom_range(0, 19) == 0) begin
            tx_quiet = !tx_quiet;
        end
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= byt;
        s_tuser  <= trk;
        do @(posedge aclk); while (!s_tready);
        if (midi_parse_byte(trk, byt, ev) || typed) begin
            pending_events.push_back(typed ? want : ev);
        end
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Builds one well-formed event on a random track and sends its bytes in order.
    task automatic send_event();
        logic [7:0]  evt [$];
        logic [7:0]  b;
        logic [3:0]  trk;
        logic [3:0]  ty;
        int unsigned pick;
        int unsigned n;
        int unsigned len;
        bit          has_payload;
        trk = 4'($urandom_range(0, 15));
        has_payload = 1'b0;
        while (prs_stage != ST_DELTA) begin
            deliver_byte(trk, 8'($urandom_range(0, 31)), 1'b0, '0);
        end
        pick = $urandom_range(0, 99);
        n = (pick < 70) ? 1 : (pick < 90) ? 2 : $urandom_range(3, 5);
        for (int i = 1; i < n; i++) begin
            evt.push_back(8'($urandom_range(128, 255)));
        end
        evt.push_back(8'($urandom_range(0, 127)));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if (pick < 35) begin
                b  = 8'($urandom_range(8'h80, 8'hEF));
                ty = b[7:4];
                evt.push_back(b);
            end else begin
                ty = run_type[trk % TRACK_COUNT];
            end
            evt.push_back(8'($urandom_range(0, 127)));
            if (ty != TYPE_PROGRAM && ty != TYPE_PRESSURE) begin
                evt.push_back(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 127)));
            end
        end else if (pick < 65) begin
            do b = 8'($urandom_range(8'hF1, 8'hFE)); while (b == SYSEX_ESC);
            evt.push_back(b);
            evt.push_back(8'($urandom_range(0, 127)));
            evt.push_back(8'($urandom_range(0, 127)));
        end else if (pick < 78) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : 3;
            evt.push_back(META_STATUS);
            evt.push_back(META_TEMPO);
            evt.push_back(8'(len));
            for (int i = 0; i < len; i++) begin
                evt.push_back(8'($urandom_range(0, 255)));
            end
        end else if (pick < 84) begin
            evt.push_back(META_STATUS);
            evt.push_back(META_EOT);
            evt.push_back(8'd0);
        end else if (pick < 92) begin
            do b = 8'($urandom_range(0, 255)); while (b == META_TEMPO);
            evt.push_back(META_STATUS);
            evt.push_back(b);
            has_payload = 1'b1;
        end else begin
            evt.push_back(($urandom_range(0, 1) == 0) ? SYSEX_START : SYSEX_ESC);
            has_payload = 1'b1;
        end
        if (has_payload) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(128, 140);
                evt.push_back(8'h81);
                evt.push_back(8'(len - 128));
            end else begin
                len = $urandom_range(0, 6);
                evt.push_back(8'(len));
            end
            for (int i = 0; i < len; i++) begin
                evt.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (evt[i]) begin
            deliver_byte(trk, evt[i], 1'b0, '0);
        end
    endtask

    task automatic flag_mismatch(input string what, input event_rec_t want,
                                 input event_rec_t seen);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected delta %0d kind %0d note %0d channel %0d tempo %0d eot %0d",
                     what, want.delta, want.kind, want.note, want.chan, want.tempo, want.eot);
            $display("    got delta %0d kind %0d note %0d channel %0d tempo %0d eot %0d",
                     seen.delta, seen.kind, seen.note, seen.chan, seen.tempo, seen.eot);
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        logic [7:0]  b;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            deliver_byte(directed_rows[i].trk, directed_rows[i].byt,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
            if ($urandom_range(0, 99) < 8) begin
                // Stray bytes; a stray length byte is kept short so that the
                // stream does not vanish into one long skip.
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (prs_stage == ST_META_LEN || prs_stage == ST_SYS_LEN) begin
                        b[7:5] = 3'd0;
                    end
                    deliver_byte(4'($urandom_range(0, 15)), b, 1'b0, '0);
                end
            end else begin
                send_event();
            end
        end
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          quiet;
        event_rec_t  seen;
        event_rec_t  want;
        taken = 0;
        quiet = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                quiet = !quiet;
            end
            // One long hold-off lets the parser fill up and stall its input.
            stall = (taken == 15) ? 300 : (quiet ? 0 : $urandom_range(0, 14));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            seen.delta = m_tdata[DELTA_W-1:0];
            seen.kind  = m_tdata[KIND_LSB +: KIND_W];
            seen.note  = m_tdata[NOTE_LSB +: NOTE_W];
            seen.chan  = m_tdata[CHAN_LSB +: CHAN_W];
            seen.tempo = m_tdata[TEMPO_LSB +: TEMPO_W];
            seen.eot   = m_tlast;
            if (pending_events.size() == 0) begin
                flag_mismatch("Unexpected result", '0, seen);
            end else begin
                want = pending_events.pop_front();
                if (seen !== want) begin
                    flag_mismatch("Result mismatch", want, seen);
                end
            end
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
